// ----- sv/wlpm_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, types and state codes of the windowed latency percentile monitor.
package wlpm_pkg;

    // Window depth and percentile refresh period.
    localparam int WINDOW         = 240;
    localparam int REFRESH_PERIOD = 16;

    // The 95th percentile rank is k = n - floor(n / PCT_DEN).
    localparam int PCT_DEN = 20;

    // Field widths.
    localparam int SAMPLE_W = 32;
    localparam int COUNT_W  = 32;
    localparam int SUM_W    = 48;

    // Derived widths for the window bookkeeping.
    localparam int FILL_W    = $clog2(WINDOW + 1);
    localparam int IDX_W     = $clog2(WINDOW);
    localparam int PCT_R_W   = $clog2(PCT_DEN);
    localparam int PHASE_W   = (REFRESH_PERIOD > 1) ? $clog2(REFRESH_PERIOD) : 1;

    // The pick tree ORs groups of cells in its first stage and the groups in its second.
    localparam int PICK_GROUP = 16;
    localparam int PICK_NGRP  = (WINDOW + PICK_GROUP - 1) / PICK_GROUP;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // Request commands.
    localparam logic CMD_RECORD = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    // One entry of a sorted chain.
    typedef struct packed {
        logic                valid;
        logic [SAMPLE_W-1:0] value;
    } wlpm_entry_t;

    // Operation broadcast to every cell of a chain.
    typedef struct packed {
        logic clear;
        logic evict;
        logic insert;
    } wlpm_cell_op_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVICT,
        ST_INSERT,
        ST_PICK1,
        ST_PICK2,
        ST_DONE
    } wlpm_state_t;

endpackage

// ----- sv/wlpm_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read-first output.
module wlpm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // A read at the address being written returns the old contents.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

endmodule

// ----- sv/wlpm_cell.sv -----
`timescale 1ns / 1ps
// One cell of the sorted sample chain: holds one entry and trades it with its neighbors.
module wlpm_cell import wlpm_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  wlpm_cell_op_t       op,
    input  logic [SAMPLE_W-1:0] key,
    input  wlpm_entry_t         lower_i,
    input  logic                lower_gt_i,
    input  wlpm_entry_t         upper_i,
    output wlpm_entry_t         entry_o,
    output logic                gt_o
);

    logic                valid_reg;
    logic                valid_next;
    logic [SAMPLE_W-1:0] value_reg;
    logic [SAMPLE_W-1:0] value_next;
    logic                ge;

    // An empty cell counts as larger than any key, so empty cells stay on top.
    always_comb begin
        ge         = valid_reg && (value_reg >= key);
        gt_o       = !valid_reg || (value_reg > key);
        valid_next = valid_reg;
        value_next = value_reg;
        if (op.clear) begin
            valid_next = 1'b0;
        end else if (op.evict && ge) begin
            // The first cell at or above the evicted value and all above it move down.
            valid_next = upper_i.valid;
            value_next = upper_i.value;
        end else if (op.insert && gt_o) begin
            // The lowest larger cell takes the key; the ones above it move up.
            if (lower_gt_i) begin
                valid_next = lower_i.valid;
                value_next = lower_i.value;
            end else begin
                valid_next = 1'b1;
                value_next = key;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign entry_o.valid = valid_reg;
    assign entry_o.value = value_reg;

endmodule

// ----- sv/wlpm_chain.sv -----
`timescale 1ns / 1ps
// Sorted chain of cells holding one window, with a two-stage registered pick tree.
module wlpm_chain import wlpm_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  wlpm_cell_op_t       op,
    input  logic [SAMPLE_W-1:0] key,
    input  logic [IDX_W-1:0]    pos,
    output logic [SAMPLE_W-1:0] pick_o
);

    wlpm_entry_t         entries [WINDOW];
    logic                gts     [WINDOW];
    logic [SAMPLE_W-1:0] pick_val [PICK_NGRP*PICK_GROUP];
    logic [SAMPLE_W-1:0] grp_reg  [PICK_NGRP];
    logic [SAMPLE_W-1:0] grp_next [PICK_NGRP];
    logic [SAMPLE_W-1:0] pick_reg;
    logic [SAMPLE_W-1:0] pick_next;

    localparam wlpm_entry_t EMPTY = '{valid: 1'b0, value: '0};

    // Row of cells, ascending from cell 0; neighbors at the ends read as empty.
    for (genvar i = 0; i < WINDOW; i++) begin : g_cell
        wlpm_entry_t lower;
        wlpm_entry_t upper;
        logic        lower_gt;

        if (i == 0) begin : g_bottom
            assign lower    = EMPTY;
            assign lower_gt = 1'b0;
        end else begin : g_mid_lo
            assign lower    = entries[i-1];
            assign lower_gt = gts[i-1];
        end

        if (i == WINDOW - 1) begin : g_top
            assign upper = EMPTY;
        end else begin : g_mid_hi
            assign upper = entries[i+1];
        end

        wlpm_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .op         (op),
            .key        (key),
            .lower_i    (lower),
            .lower_gt_i (lower_gt),
            .upper_i    (upper),
            .entry_o    (entries[i]),
            .gt_o       (gts[i])
        );
    end

    // Each cell offers its value only when it sits at the requested rank.
    for (genvar i = 0; i < PICK_NGRP * PICK_GROUP; i++) begin : g_pick
        if (i < WINDOW) begin : g_used
            assign pick_val[i] = (pos == IDX_W'(i)) ? entries[i].value : '0;
        end else begin : g_pad
            assign pick_val[i] = '0;
        end
    end

    // First tree stage: OR within each group of cells.
    always_comb begin
        for (int g = 0; g < PICK_NGRP; g++) begin
            grp_next[g] = '0;
            for (int j = 0; j < PICK_GROUP; j++) begin
                grp_next[g] = grp_next[g] | pick_val[g*PICK_GROUP + j];
            end
        end
    end

    // Second tree stage: OR across the groups.
    always_comb begin
        pick_next = '0;
        for (int g = 0; g < PICK_NGRP; g++) begin
            pick_next = pick_next | grp_reg[g];
        end
    end

    always_ff @(posedge aclk) begin
        for (int g = 0; g < PICK_NGRP; g++) begin
            grp_reg[g] <= grp_next[g];
        end
        pick_reg <= pick_next;
    end

    assign pick_o = pick_reg;

endmodule

// ----- sv/windowed_latency_percentile_monitor.sv -----
`timescale 1ns / 1ps
// Top level of the windowed latency percentile monitor: sequencer, statistics and result register.
//
// Each request either records a total/backend latency pair or clears all statistics, and
// returns one result with the sample count, saturating sums, peaks and the held 95th
// percentile of the last WINDOW samples of each kind. Each window is a sorted chain of cells
// beside a sample RAM that remembers arrival order. A record request steps the sequencer
// through its states in order: the accepting cycle updates the counters and writes the RAM,
// then ST_EVICT removes the oldest sample from the chains once the window is full, ST_INSERT
// inserts the new sample, ST_PICK1 and ST_PICK2 run the registered pick tree that reads the
// rank k = n - floor(n/20) out of the chain, and ST_DONE loads the result register. A clear
// request goes from acceptance straight to ST_DONE. The last step of either waits while the
// previous result is still held at the output. A new request is taken as soon as the
// sequencer is idle, even while the previous result still waits at the output.
module windowed_latency_percentile_monitor import wlpm_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_command,
    input  logic [SAMPLE_W-1:0] s_total_sample,
    input  logic [SAMPLE_W-1:0] s_backend_sample,

    output logic                m_valid,
    input  logic                m_ready,
    output logic [COUNT_W-1:0]  m_sample_count,
    output logic [SUM_W-1:0]    m_total_sum,
    output logic [SAMPLE_W-1:0] m_total_peak,
    output logic [SAMPLE_W-1:0] m_total_pct95,
    output logic [SUM_W-1:0]    m_backend_sum,
    output logic [SAMPLE_W-1:0] m_backend_peak,
    output logic [SAMPLE_W-1:0] m_backend_pct95
);

    wlpm_state_t state_reg;
    wlpm_state_t state_next;

    logic accept;
    logic rec_accept;
    logic clr_accept;
    logic load_out;

    // Statistics.
    logic [COUNT_W-1:0]  count_reg;
    logic [COUNT_W-1:0]  count_next;
    logic [SUM_W-1:0]    tsum_reg;
    logic [SUM_W-1:0]    tsum_next;
    logic [SUM_W-1:0]    bsum_reg;
    logic [SUM_W-1:0]    bsum_next;
    logic [SAMPLE_W-1:0] tpeak_reg;
    logic [SAMPLE_W-1:0] tpeak_next;
    logic [SAMPLE_W-1:0] bpeak_reg;
    logic [SAMPLE_W-1:0] bpeak_next;
    logic [SAMPLE_W-1:0] tpct_reg;
    logic [SAMPLE_W-1:0] tpct_next;
    logic [SAMPLE_W-1:0] bpct_reg;
    logic [SAMPLE_W-1:0] bpct_next;
    logic [SUM_W:0]      tsum_wide;
    logic [SUM_W:0]      bsum_wide;

    // Window bookkeeping.
    logic [FILL_W-1:0]  fill_reg;
    logic [FILL_W-1:0]  fill_next;
    logic [IDX_W-1:0]   oldest_reg;
    logic [IDX_W-1:0]   oldest_next;
    logic [FILL_W-1:0]  quot_reg;
    logic [FILL_W-1:0]  quot_next;
    logic [PCT_R_W-1:0] rem_reg;
    logic [PCT_R_W-1:0] rem_next;
    logic [IDX_W-1:0]   pos_reg;
    logic [IDX_W-1:0]   pos_next;
    logic [PHASE_W-1:0] phase_reg;
    logic [PHASE_W-1:0] phase_next;
    logic               full_reg;
    logic               full_next;
    logic               refresh_reg;
    logic               refresh_next;
    logic [IDX_W:0]     slot_sum;
    logic [IDX_W-1:0]   slot;
    logic               window_full;

    // Held sample of the request in flight.
    logic [SAMPLE_W-1:0] ts_reg;
    logic [SAMPLE_W-1:0] bs_reg;

    // Sample RAM and chains.
    logic [2*SAMPLE_W-1:0] ram_rd_data;
    wlpm_cell_op_t         chain_op;
    logic [SAMPLE_W-1:0]   tkey;
    logic [SAMPLE_W-1:0]   bkey;
    logic [SAMPLE_W-1:0]   tpick;
    logic [SAMPLE_W-1:0]   bpick;

    // Result register.
    logic                m_valid_reg;
    logic                m_valid_next;
    logic [COUNT_W-1:0]  m_count_reg;
    logic [SUM_W-1:0]    m_tsum_reg;
    logic [SAMPLE_W-1:0] m_tpeak_reg;
    logic [SAMPLE_W-1:0] m_tpct_reg;
    logic [SUM_W-1:0]    m_bsum_reg;
    logic [SAMPLE_W-1:0] m_bpeak_reg;
    logic [SAMPLE_W-1:0] m_bpct_reg;

    // Sequencer state register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Sequencer next state and control outputs.
    always_comb begin
        state_next      = state_reg;
        s_ready         = 1'b0;
        load_out        = 1'b0;
        chain_op.clear  = 1'b0;
        chain_op.evict  = 1'b0;
        chain_op.insert = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    chain_op.clear = (s_command == CMD_CLEAR);
                    state_next     = (s_command == CMD_CLEAR) ? ST_DONE : ST_EVICT;
                end
            end
            ST_EVICT: begin
                chain_op.evict = full_reg;
                state_next     = ST_INSERT;
            end
            ST_INSERT: begin
                chain_op.insert = 1'b1;
                state_next      = ST_PICK1;
            end
            ST_PICK1: begin
                state_next = ST_PICK2;
            end
            ST_PICK2: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign accept     = s_valid && s_ready;
    assign rec_accept = accept && (s_command == CMD_RECORD);
    assign clr_accept = accept && (s_command == CMD_CLEAR);

    // Statistics and window bookkeeping updates on an accepted request.
    always_comb begin
        tsum_wide   = {1'b0, tsum_reg} + (SUM_W+1)'(s_total_sample);
        bsum_wide   = {1'b0, bsum_reg} + (SUM_W+1)'(s_backend_sample);
        window_full = (fill_reg == FILL_W'(WINDOW));
        slot_sum    = (IDX_W+1)'(oldest_reg) + (IDX_W+1)'(fill_reg[IDX_W-1:0]);
        if (window_full) begin
            slot = oldest_reg;
        end else if (slot_sum >= (IDX_W+1)'(WINDOW)) begin
            slot = IDX_W'(slot_sum - (IDX_W+1)'(WINDOW));
        end else begin
            slot = slot_sum[IDX_W-1:0];
        end

        count_next   = count_reg;
        tsum_next    = tsum_reg;
        bsum_next    = bsum_reg;
        tpeak_next   = tpeak_reg;
        bpeak_next   = bpeak_reg;
        fill_next    = fill_reg;
        oldest_next  = oldest_reg;
        quot_next    = quot_reg;
        rem_next     = rem_reg;
        pos_next     = pos_reg;
        phase_next   = phase_reg;
        full_next    = full_reg;
        refresh_next = refresh_reg;

        if (clr_accept) begin
            count_next   = '0;
            tsum_next    = '0;
            bsum_next    = '0;
            tpeak_next   = '0;
            bpeak_next   = '0;
            fill_next    = '0;
            oldest_next  = '0;
            quot_next    = '0;
            rem_next     = '0;
            pos_next     = '0;
            phase_next   = '0;
            full_next    = 1'b0;
            refresh_next = 1'b0;
        end else if (rec_accept) begin
            count_next = count_reg + COUNT_W'(1);
            tsum_next  = tsum_wide[SUM_W] ? SUM_MAX : tsum_wide[SUM_W-1:0];
            bsum_next  = bsum_wide[SUM_W] ? SUM_MAX : bsum_wide[SUM_W-1:0];
            if (s_total_sample > tpeak_reg) begin
                tpeak_next = s_total_sample;
            end
            if (s_backend_sample > bpeak_reg) begin
                bpeak_next = s_backend_sample;
            end

            // Grow the window, or slide it once full; track floor(fill / 20).
            full_next = window_full;
            if (window_full) begin
                if (oldest_reg == IDX_W'(WINDOW - 1)) begin
                    oldest_next = '0;
                end else begin
                    oldest_next = oldest_reg + IDX_W'(1);
                end
            end else begin
                fill_next = fill_reg + FILL_W'(1);
                if (rem_reg == PCT_R_W'(PCT_DEN - 1)) begin
                    rem_next  = '0;
                    quot_next = quot_reg + FILL_W'(1);
                end else begin
                    rem_next = rem_reg + PCT_R_W'(1);
                end
            end
            pos_next = IDX_W'(fill_next - FILL_W'(1) - quot_next);

            // The phase follows the count modulo the refresh period, also across a wrap.
            if ((count_next == '0) || (phase_reg == PHASE_W'(REFRESH_PERIOD - 1))) begin
                phase_next = '0;
            end else begin
                phase_next = phase_reg + PHASE_W'(1);
            end
            refresh_next = (count_next <= COUNT_W'(REFRESH_PERIOD)) || (phase_next == '0);
        end
    end

    // Percentiles: cleared with the statistics; refreshed in ST_DONE when refresh_reg is set.
    always_comb begin
        tpct_next = tpct_reg;
        bpct_next = bpct_reg;
        if (clr_accept) begin
            tpct_next = '0;
            bpct_next = '0;
        end else if ((state_reg == ST_DONE) && refresh_reg) begin
            tpct_next = tpick;
            bpct_next = bpick;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            tsum_reg    <= '0;
            bsum_reg    <= '0;
            tpeak_reg   <= '0;
            bpeak_reg   <= '0;
            tpct_reg    <= '0;
            bpct_reg    <= '0;
            fill_reg    <= '0;
            oldest_reg  <= '0;
            quot_reg    <= '0;
            rem_reg     <= '0;
            pos_reg     <= '0;
            phase_reg   <= '0;
            full_reg    <= 1'b0;
            refresh_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            tsum_reg    <= tsum_next;
            bsum_reg    <= bsum_next;
            tpeak_reg   <= tpeak_next;
            bpeak_reg   <= bpeak_next;
            tpct_reg    <= tpct_next;
            bpct_reg    <= bpct_next;
            fill_reg    <= fill_next;
            oldest_reg  <= oldest_next;
            quot_reg    <= quot_next;
            rem_reg     <= rem_next;
            pos_reg     <= pos_next;
            phase_reg   <= phase_next;
            full_reg    <= full_next;
            refresh_reg <= refresh_next;
        end
    end

    // Samples of the request in flight, used as insertion keys.
    always_ff @(posedge aclk) begin
        if (rec_accept) begin
            ts_reg <= s_total_sample;
            bs_reg <= s_backend_sample;
        end
    end

    // Arrival-order store of both windows; the read returns the sample about to be evicted.
    wlpm_ram #(
        .WIDTH (2 * SAMPLE_W),
        .DEPTH (WINDOW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (rec_accept),
        .wr_addr (slot),
        .wr_data ({s_total_sample, s_backend_sample}),
        .rd_en   (rec_accept),
        .rd_addr (oldest_reg),
        .rd_data (ram_rd_data)
    );

    // Chains take the evicted sample as key in the evict step and the new one otherwise.
    assign tkey = chain_op.evict ? ram_rd_data[2*SAMPLE_W-1:SAMPLE_W] : ts_reg;
    assign bkey = chain_op.evict ? ram_rd_data[SAMPLE_W-1:0] : bs_reg;

    wlpm_chain u_total_chain (
        .aclk    (aclk),
        .aresetn (aresetn),
        .op      (chain_op),
        .key     (tkey),
        .pos     (pos_reg),
        .pick_o  (tpick)
    );

    wlpm_chain u_backend_chain (
        .aclk    (aclk),
        .aresetn (aresetn),
        .op      (chain_op),
        .key     (bkey),
        .pos     (pos_reg),
        .pick_o  (bpick)
    );

    // Result register, loaded with the statistics as they stand after the request.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_count_reg <= count_reg;
            m_tsum_reg  <= tsum_reg;
            m_tpeak_reg <= tpeak_reg;
            m_tpct_reg  <= tpct_next;
            m_bsum_reg  <= bsum_reg;
            m_bpeak_reg <= bpeak_reg;
            m_bpct_reg  <= bpct_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_sample_count  = m_count_reg;
    assign m_total_sum     = m_tsum_reg;
    assign m_total_peak    = m_tpeak_reg;
    assign m_total_pct95   = m_tpct_reg;
    assign m_backend_sum   = m_bsum_reg;
    assign m_backend_peak  = m_bpeak_reg;
    assign m_backend_pct95 = m_bpct_reg;

`ifndef SYNTH
    // The fill level never passes the window depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_W'(WINDOW))
        else $error("fill level beyond window depth");

    // The picked rank always lies inside the filled part of the chain.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (fill_reg != '0) |-> (FILL_W'(pos_reg) < fill_reg))
        else $error("percentile rank outside the window");

    // The oldest slot only moves once the window is full.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (oldest_reg != '0) |-> (fill_reg == FILL_W'(WINDOW)))
        else $error("window slid before it was full");

    // A clear leaves count and window empty in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        clr_accept |=> ((count_reg == '0) && (fill_reg == '0) && (state_reg == ST_DONE)))
        else $error("clear request did not empty the statistics");

    // A new result appears only out of the final sequencer step.
    assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |-> ((state_reg == ST_DONE) && (!m_valid_reg || m_ready)))
        else $error("result loaded while the output was occupied");
`endif

endmodule

// ----- dv/windowed_latency_percentile_monitor_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the windowed latency percentile monitor.
module windowed_latency_percentile_monitor_tb;
    import wlpm_pkg::*;

    // Statistics carried by one result.
    typedef struct packed {
        logic [COUNT_W-1:0]  sample_count;
        logic [SUM_W-1:0]    total_sum;
        logic [SAMPLE_W-1:0] total_peak;
        logic [SAMPLE_W-1:0] total_pct95;
        logic [SUM_W-1:0]    backend_sum;
        logic [SAMPLE_W-1:0] backend_peak;
        logic [SAMPLE_W-1:0] backend_pct95;
    } latency_stats_t;

    // Tracks the latency statistics the block should report and checks its results.
    class latency_stats_tracker;
        logic [SAMPLE_W-1:0] total_hist [WINDOW];
        logic [SAMPLE_W-1:0] backend_hist [WINDOW];
        int unsigned         fill;
        int unsigned         oldest;
        logic [COUNT_W-1:0]  count;
        logic [SUM_W-1:0]    total_acc;
        logic [SUM_W-1:0]    backend_acc;
        logic [SAMPLE_W-1:0] total_max;
        logic [SAMPLE_W-1:0] backend_max;
        logic [SAMPLE_W-1:0] total_p95;
        logic [SAMPLE_W-1:0] backend_p95;
        latency_stats_t      pending_stats [$];
        int unsigned         error_count;

        function new();
            error_count = 0;
            clear_all();
        endfunction

        function void clear_all();
            fill        = 0;
            oldest      = 0;
            count       = '0;
            total_acc   = '0;
            backend_acc = '0;
            total_max   = '0;
            backend_max = '0;
            total_p95   = '0;
            backend_p95 = '0;
        endfunction

        function logic [SUM_W-1:0] sat_add(logic [SUM_W-1:0] acc, logic [SAMPLE_W-1:0] v);
            logic [SUM_W:0] wide;
            wide = {1'b0, acc} + {{(SUM_W + 1 - SAMPLE_W){1'b0}}, v};
            return (wide > {1'b0, SUM_MAX}) ? SUM_MAX : wide[SUM_W-1:0];
        endfunction

        // Rank ceil(19n/20) of the filled part of one window, found by insertion sort.
        function logic [SAMPLE_W-1:0] window_p95(bit use_backend);
            logic [SAMPLE_W-1:0] ordered [WINDOW];
            logic [SAMPLE_W-1:0] key;
            int unsigned         rank;
            int                  i;
            int                  j;
            if (fill == 0) return '0;
            for (i = 0; i < fill; i++) begin
                ordered[i] = use_backend ? backend_hist[i] : total_hist[i];
            end
            for (i = 1; i < fill; i++) begin
                key = ordered[i];
                j   = i - 1;
                while (j >= 0 && ordered[j] > key) begin
                    ordered[j+1] = ordered[j];
                    j--;
                end
                ordered[j+1] = key;
            end
            rank = ((PCT_DEN - 1) * fill + (PCT_DEN - 1)) / PCT_DEN;
            if (rank > fill) rank = fill;
            return ordered[rank-1];
        endfunction

        // Applies one accepted request and queues the statistics it should return.
        function void note_request(logic cmd, logic [SAMPLE_W-1:0] ts, logic [SAMPLE_W-1:0] bs);
            int unsigned    slot;
            latency_stats_t want;
            if (cmd == CMD_CLEAR) begin
                clear_all();
            end else begin
                count       = count + 1'b1;
                total_acc   = sat_add(total_acc, ts);
                backend_acc = sat_add(backend_acc, bs);
                if (ts > total_max) total_max = ts;
                if (bs > backend_max) backend_max = bs;
                // Fill the window first, then overwrite the oldest sample.
                if (fill < WINDOW) begin
                    slot = (oldest + fill) % WINDOW;
                    fill++;
                end else begin
                    slot   = oldest;
                    oldest = (oldest + 1) % WINDOW;
                end
                total_hist[slot]   = ts;
                backend_hist[slot] = bs;
                // The percentile is refreshed early on and then once per period.
                if (count <= REFRESH_PERIOD || (count % REFRESH_PERIOD) == 0) begin
                    total_p95   = window_p95(1'b0);
                    backend_p95 = window_p95(1'b1);
                end
            end
            want.sample_count  = count;
            want.total_sum     = total_acc;
            want.total_peak    = total_max;
            want.total_pct95   = total_p95;
            want.backend_sum   = backend_acc;
            want.backend_peak  = backend_max;
            want.backend_pct95 = backend_p95;
            pending_stats.insert(pending_stats.size(), want);
        endfunction

        function void report_mismatch(string field, logic [SUM_W-1:0] want, logic [SUM_W-1:0] got);
            $error("%s: expected %0h, actual %0h", field, want, got);
            error_count++;
        endfunction

        // Compares one accepted result with the oldest expectation.
        function void check_stats(latency_stats_t got);
            latency_stats_t want;
            if (pending_stats.size() == 0) begin
                $error("result with no request outstanding: count %0h", got.sample_count);
                error_count++;
                return;
            end
            want = pending_stats.pop_front();
            if (got.sample_count !== want.sample_count)
                report_mismatch("sample_count", want.sample_count, got.sample_count);
            if (got.total_sum !== want.total_sum)
                report_mismatch("total_sum", want.total_sum, got.total_sum);
            if (got.total_peak !== want.total_peak)
                report_mismatch("total_peak", want.total_peak, got.total_peak);
            if (got.total_pct95 !== want.total_pct95)
                report_mismatch("total_pct95", want.total_pct95, got.total_pct95);
            if (got.backend_sum !== want.backend_sum)
                report_mismatch("backend_sum", want.backend_sum, got.backend_sum);
            if (got.backend_peak !== want.backend_peak)
                report_mismatch("backend_peak", want.backend_peak, got.backend_peak);
            if (got.backend_pct95 !== want.backend_pct95)
                report_mismatch("backend_pct95", want.backend_pct95, got.backend_pct95);
        endfunction
    endclass

    localparam int RANDOM_PER_PHASE = 250;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int TOP_VALUE_COUNT  = 260;
    localparam int DRAIN_CYCLES     = 12;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic                s_command;
    logic [SAMPLE_W-1:0] s_total_sample;
    logic [SAMPLE_W-1:0] s_backend_sample;
    logic                m_valid;
    logic                m_ready;
    logic [COUNT_W-1:0]  m_sample_count;
    logic [SUM_W-1:0]    m_total_sum;
    logic [SAMPLE_W-1:0] m_total_peak;
    logic [SAMPLE_W-1:0] m_total_pct95;
    logic [SUM_W-1:0]    m_backend_sum;
    logic [SAMPLE_W-1:0] m_backend_peak;
    logic [SAMPLE_W-1:0] m_backend_pct95;

    latency_stats_tracker stats_sb;
    int unsigned          send_idle_pct;
    int unsigned          recv_stall_pct;
    bit                   hold_off_request;

    windowed_latency_percentile_monitor u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_total_sample   (s_total_sample),
        .s_backend_sample (s_backend_sample),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_sample_count   (m_sample_count),
        .m_total_sum      (m_total_sum),
        .m_total_peak     (m_total_peak),
        .m_total_pct95    (m_total_pct95),
        .m_backend_sum    (m_backend_sum),
        .m_backend_peak   (m_backend_peak),
        .m_backend_pct95  (m_backend_pct95)
    );

    // Free-running clock.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard limit on the run.
    initial begin
        #30_000_000;
        $display("status: fail");
        $finish;
    end

    // Note every accepted request.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            stats_sb.note_request(s_command, s_total_sample, s_backend_sample);
        end
    end

    // Check every accepted result.
    always @(posedge aclk) begin : result_monitor
        latency_stats_t seen;
        if (aresetn && m_valid && m_ready) begin
            seen.sample_count  = m_sample_count;
            seen.total_sum     = m_total_sum;
            seen.total_peak    = m_total_peak;
            seen.total_pct95   = m_total_pct95;
            seen.backend_sum   = m_backend_sum;
            seen.backend_peak  = m_backend_peak;
            seen.backend_pct95 = m_backend_pct95;
            stats_sb.check_stats(seen);
        end
    end

    // Result side: random stalls, plus one long hold-off on request.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge aclk);
            end else if (recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct) begin
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Offers one request, with random idle cycles ahead of it, and waits until it is taken.
    task automatic send_request(input logic cmd, input logic [SAMPLE_W-1:0] ts,
                                input logic [SAMPLE_W-1:0] bs);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_command        <= cmd;
        s_total_sample   <= ts;
        s_backend_sample <= bs;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Latency values drawn from several shapes: full range, ties, near the top, single bits, a mid range, 16 bits.
    function automatic logic [SAMPLE_W-1:0] pick_latency();
        case ($urandom_range(5))
            0: return $urandom;
            1: return $urandom_range(15);
            2: return 32'hFFFF_FFFF - $urandom_range(15);
            3: return 32'h1 << $urandom_range(31);
            4: return $urandom_range(100_000, 1_000);
            default: return $urandom & 32'h0000_FFFF;
        endcase
    endfunction

    // Short directed sequence: field extremes, clears and the early refresh boundary.
    task automatic run_directed();
        int i;
        send_request(CMD_RECORD, 32'h0000_0000, 32'h0000_0000);
        send_request(CMD_RECORD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(CMD_RECORD, 32'hAAAA_AAAA, 32'h5555_5555);
        send_request(CMD_RECORD, 32'h5555_5555, 32'hAAAA_AAAA);
        send_request(CMD_RECORD, 32'h0000_0001, 32'hFFFF_FFFE);
        // A clear ignores its samples; a second clear hits an empty window.
        send_request(CMD_CLEAR, 32'hDEAD_BEEF, 32'hFFFF_FFFF);
        send_request(CMD_CLEAR, 32'h0000_0000, 32'h0000_0000);
        send_request(CMD_RECORD, 32'd7, 32'd3);
        // Cross the point where the percentile starts being held.
        for (i = 0; i < 17; i++) begin
            send_request(CMD_RECORD, 32'(i * 37 % 23), 32'(100 - i));
        end
    endtask

    // Fills the window with all-ones samples and keeps recording so that it slides, between two clears.
    task automatic run_top_values();
        int i;
        send_request(CMD_CLEAR, 32'h0, 32'h0);
        for (i = 0; i < TOP_VALUE_COUNT; i++) begin
            send_request(CMD_RECORD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        end
        send_request(CMD_CLEAR, 32'h0, 32'h0);
    endtask

    // Random requests: mostly records, with a rare clear so the windows fill and wrap.
    task automatic run_random(input int unsigned items, input bit with_hold);
        int i;
        for (i = 0; i < items; i++) begin
            if (with_hold && i == items / 3) hold_off_request = 1'b1;
            if ($urandom_range(399) == 0) begin
                send_request(CMD_CLEAR, $urandom, $urandom);
            end else begin
                send_request(CMD_RECORD, pick_latency(), pick_latency());
            end
        end
    endtask

    // Reset, stimulus phases, drain and verdict.
    initial begin
        stats_sb         = new();
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        hold_off_request = 1'b0;
        aresetn          = 1'b0;
        s_valid          = 1'b0;
        s_command        = CMD_RECORD;
        s_total_sample   = '0;
        s_backend_sample = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_directed();
        run_top_values();

        // No idling, with one long hold-off on the result side.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random(RANDOM_PER_PHASE, 1'b1);
        // Idle sender.
        send_idle_pct  = 53;
        recv_stall_pct = 0;
        run_random(RANDOM_PER_PHASE, 1'b0);
        // Stalling receiver.
        send_idle_pct  = 0;
        recv_stall_pct = 53;
        run_random(RANDOM_PER_PHASE, 1'b0);
        // Both sides idle.
        send_idle_pct  = 33;
        recv_stall_pct = 33;
        run_random(RANDOM_PER_PHASE, 1'b0);
        s_valid <= 1'b0;

        // Drain outstanding results, then watch for strays.
        while (stats_sb.pending_stats.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (stats_sb.error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/wlpm_pkg.sv
sv/wlpm_ram.sv
sv/wlpm_cell.sv
sv/wlpm_chain.sv
sv/windowed_latency_percentile_monitor.sv
dv/windowed_latency_percentile_monitor_tb.sv
